### src/led_pulse_gamma_brightness_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the breathing LED gamma block
// Shared concurrent property wrappers, sampled on aclk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef LED_PULSE_GAMMA_BRIGHTNESS_ASSERT_SVH
`define LED_PULSE_GAMMA_BRIGHTNESS_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define LPGB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lpgb: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define LPGB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lpgb: next-cycle check failed");

`endif

### src/lpgb_pkg.sv
// ----------------------------------------------------------------------------
// lpgb_pkg
// Widths, register indexes, the gamma table and the beat types shared by
// the breathing LED gamma pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpgb_pkg;

    // Time and division widths.
    localparam int TIME_WIDTH    = 24;
    localparam int PEAK_W        = TIME_WIDTH - 1;
    localparam int QUOT_W        = 7;
    localparam int QIDX_W        = $clog2(QUOT_W);
    localparam int NUM_W         = PEAK_W + QUOT_W;
    localparam int GAMMA_ENTRIES = 100;

    // Color channels.
    localparam int LEVEL_W = 8;
    localparam int NUM_CH  = 4;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_WHITE = 3;

    // Gamma scaling: product of level and gamma, then divide by 100 through
    // a reciprocal multiply that is exact for products up to 25500.
    localparam int GAMMA_W     = 7;
    localparam int PROD_W      = LEVEL_W + GAMMA_W;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int SCALED_W    = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

    localparam logic [QUOT_W-1:0] PCT_MAX  = QUOT_W'(GAMMA_ENTRIES - 1);
    localparam logic [QUOT_W-1:0] QUOT_MAX = QUOT_W'(GAMMA_ENTRIES);

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [TIME_WIDTH-1:0] PULSE_RESET = TIME_WIDTH'(1000);
    localparam logic [LEVEL_W-1:0]    LEVEL_RESET = LEVEL_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_LENGTH = 3'd0,
        CFG_RED_LEVEL    = 3'd1,
        CFG_GREEN_LEVEL  = 3'd2,
        CFG_BLUE_LEVEL   = 3'd3,
        CFG_WHITE_LEVEL  = 3'd4
    } lpgb_cfg_e;

    typedef logic [NUM_CH-1:0][LEVEL_W-1:0] lpgb_level_t;

    // Beat handed from cell to cell along the divider chain.
    typedef struct packed {
        logic              zero;
        logic [NUM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
    } lpgb_div_t;

    // Gamma curve, indexed by percent 0..99, values 0..100.
    localparam logic [GAMMA_W-1:0] GAMMA_ROM [GAMMA_ENTRIES] = '{
         7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
         7'd0,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
         7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,  7'd3,  7'd4,  7'd4,
         7'd4,  7'd5,  7'd5,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,  7'd8,  7'd9,
         7'd9, 7'd10, 7'd11, 7'd11, 7'd12, 7'd13, 7'd14, 7'd14, 7'd15, 7'd16,
        7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26,
        7'd27, 7'd28, 7'd30, 7'd31, 7'd32, 7'd33, 7'd35, 7'd36, 7'd38, 7'd39,
        7'd41, 7'd42, 7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd54, 7'd56,
        7'd57, 7'd59, 7'd61, 7'd63, 7'd65, 7'd67, 7'd69, 7'd71, 7'd74, 7'd76,
        7'd78, 7'd80, 7'd83, 7'd85, 7'd87, 7'd90, 7'd92, 7'd95, 7'd97, 7'd100
    };

endpackage

### src/lpgb_fold.sv
// ----------------------------------------------------------------------------
// lpgb_fold
// Front stage: drops beats past the pulse end, folds the time around the
// peak and forms the dividend folded * 100 for the divider chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpgb_fold (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [lpgb_pkg::TIME_WIDTH-1:0] pulse_len,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lpgb_pkg::TIME_WIDTH-1:0] in_time,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lpgb_pkg::lpgb_div_t             out_data
);
    import lpgb_pkg::*;

    logic                  valid_reg;
    lpgb_div_t             data_reg;
    lpgb_div_t             data_next;
    logic                  in_range;
    logic [PEAK_W-1:0]     peak;
    logic [TIME_WIDTH-1:0] twice_peak;
    logic [TIME_WIDTH-1:0] mirror;
    logic [PEAK_W-1:0]     folded;
    logic [NUM_W-1:0]      folded_w;

    assign in_ready = !valid_reg || out_ready;

    // Fold the time into a triangle and scale it by 100 (64 + 32 + 4).
    always_comb begin
        in_range   = in_time < pulse_len;
        peak       = pulse_len[TIME_WIDTH-1:1];
        twice_peak = {peak, 1'b0};
        mirror     = twice_peak - in_time;
        if (in_time <= TIME_WIDTH'(peak)) begin
            folded = in_time[PEAK_W-1:0];
        end else if (twice_peak >= in_time) begin
            folded = mirror[PEAK_W-1:0];
        end else begin
            folded = '0;
        end
        folded_w       = NUM_W'(folded);
        data_next.zero = in_time == '0;
        data_next.rem  = (folded_w << 6) + (folded_w << 5) + (folded_w << 2);
        data_next.quot = '0;
    end

    // A beat past the pulse end is taken but leaves a bubble.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/lpgb_div_cell.sv
// ----------------------------------------------------------------------------
// lpgb_div_cell
// One cell of the restoring divider chain: settles one quotient bit by a
// trial subtract of the shifted peak and hands the beat to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpgb_div_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lpgb_pkg::QIDX_W-1:0]  bit_idx,
    input  logic [lpgb_pkg::PEAK_W-1:0]  divisor,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lpgb_pkg::lpgb_div_t          in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lpgb_pkg::lpgb_div_t          out_data
);
    import lpgb_pkg::*;

    logic             valid_reg;
    lpgb_div_t        data_reg;
    lpgb_div_t        data_next;
    logic [NUM_W-1:0] shifted;
    logic             fits;

    assign in_ready = !valid_reg || out_ready;

    // Trial subtract of divisor * 2^bit_idx.
    always_comb begin
        shifted   = NUM_W'(divisor) << bit_idx;
        fits      = in_data.rem >= shifted;
        data_next = in_data;
        if (fits) begin
            data_next.rem = in_data.rem - shifted;
        end
        data_next.quot[bit_idx] = fits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/lpgb_scale.sv
// ----------------------------------------------------------------------------
// lpgb_scale
// Back end: clamps the percent, looks up gamma, multiplies each channel
// level by gamma and divides by 100 into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpgb_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lpgb_pkg::lpgb_level_t         levels,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lpgb_pkg::lpgb_div_t           in_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lpgb_pkg::LEVEL_W-1:0]  m_red_out,
    output logic [lpgb_pkg::LEVEL_W-1:0]  m_green_out,
    output logic [lpgb_pkg::LEVEL_W-1:0]  m_blue_out,
    output logic [lpgb_pkg::LEVEL_W-1:0]  m_white_out
);
    import lpgb_pkg::*;

    logic                    gamma_valid_reg;
    logic [GAMMA_W-1:0]      gamma_reg;
    logic [GAMMA_W-1:0]      gamma_next;
    logic [QUOT_W-1:0]       pct;
    logic                    prod_valid_reg;
    logic [PROD_W-1:0]       prod_reg [NUM_CH];
    logic [PROD_W-1:0]       prod_next [NUM_CH];
    logic                    out_valid_reg;
    logic [LEVEL_W-1:0]      out_reg [NUM_CH];
    logic [LEVEL_W-1:0]      out_next [NUM_CH];
    logic [SCALED_W-1:0]     scaled [NUM_CH];
    logic                    gamma_ready;
    logic                    prod_ready;
    logic                    out_ready;

    // Ready ripples back so bubbles collapse.
    assign out_ready   = !out_valid_reg || m_ready;
    assign prod_ready  = !prod_valid_reg || out_ready;
    assign gamma_ready = !gamma_valid_reg || prod_ready;
    assign in_ready    = gamma_ready;

    // Clamp the percent and read the gamma table; time zero forces black.
    always_comb begin
        pct = (in_data.quot > PCT_MAX) ? PCT_MAX : in_data.quot;
        gamma_next = in_data.zero ? '0 : GAMMA_ROM[pct];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_valid_reg <= 1'b0;
        end else if (gamma_ready) begin
            gamma_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (gamma_ready && in_valid) begin
            gamma_reg <= gamma_next;
        end
    end

    // Level times gamma for each channel.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod_next[c] = PROD_W'(levels[c]) * PROD_W'(gamma_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= gamma_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && gamma_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

    // Divide by 100 through the reciprocal multiply.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            scaled[c]   = SCALED_W'(prod_reg[c]) * SCALED_W'(RECIP_100);
            out_next[c] = scaled[c][RECIP_SHIFT +: LEVEL_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && prod_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_red_out   = out_reg[CH_RED];
    assign m_green_out = out_reg[CH_GREEN];
    assign m_blue_out  = out_reg[CH_BLUE];
    assign m_white_out = out_reg[CH_WHITE];

endmodule

### src/led_pulse_gamma_brightness.sv
// Throughput: one beat per cycle while the m_ side accepts results; one fold
// stage, seven divider cells (one quotient bit each) and three gamma/scale
// stages, all with local ready.
// A beat at or past the pulse length is taken and yields no result.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// registers: pulse length 1000, all four channel levels 255.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// led_pulse_gamma_brightness
// Breathing LED color: folds elapsed time into a triangle, turns it into a
// percent through a chain of divider cells, and gamma-scales four channels.
// ----------------------------------------------------------------------------

`include "led_pulse_gamma_brightness_assert.svh"

module led_pulse_gamma_brightness (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpgb_pkg::TIME_WIDTH-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lpgb_pkg::TIME_WIDTH-1:0]  s_elapsed_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lpgb_pkg::LEVEL_W-1:0]     m_red_out,
    output logic [lpgb_pkg::LEVEL_W-1:0]     m_green_out,
    output logic [lpgb_pkg::LEVEL_W-1:0]     m_blue_out,
    output logic [lpgb_pkg::LEVEL_W-1:0]     m_white_out
);
    import lpgb_pkg::*;

    logic [TIME_WIDTH-1:0] pulse_len_reg;
    lpgb_level_t           level_reg;
    logic [PEAK_W-1:0]     peak;
    logic                  div_valid [QUOT_W+1];
    logic                  div_ready [QUOT_W+1];
    lpgb_div_t             div_data  [QUOT_W+1];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_len_reg <= PULSE_RESET;
            level_reg     <= {NUM_CH{LEVEL_RESET}};
        end else if (cfg_valid) begin
            case (lpgb_cfg_e'(cfg_index))
                CFG_PULSE_LENGTH: pulse_len_reg <= cfg_data;
                CFG_RED_LEVEL:    level_reg[CH_RED]   <= cfg_data[LEVEL_W-1:0];
                CFG_GREEN_LEVEL:  level_reg[CH_GREEN] <= cfg_data[LEVEL_W-1:0];
                CFG_BLUE_LEVEL:   level_reg[CH_BLUE]  <= cfg_data[LEVEL_W-1:0];
                CFG_WHITE_LEVEL:  level_reg[CH_WHITE] <= cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign peak = pulse_len_reg[TIME_WIDTH-1:1];

    // Front stage.
    lpgb_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pulse_len (pulse_len_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_time   (s_elapsed_ms),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // Divider chain, most significant quotient bit first.
    for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
        lpgb_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .bit_idx   (QIDX_W'(QUOT_W - 1 - i)),
            .divisor   (peak),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // Gamma lookup and channel scaling.
    lpgb_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .levels      (level_reg),
        .in_valid    (div_valid[QUOT_W]),
        .in_ready    (div_ready[QUOT_W]),
        .in_data     (div_data[QUOT_W]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_white_out (m_white_out)
    );

    // A beat past the pulse end leaves the front stage empty.
    `LPGB_ASSERT_NXT(a_drop_past_end, s_valid && s_ready && (s_elapsed_ms >= pulse_len_reg), !div_valid[0])
    // The folded time never exceeds the peak, so the quotient stays at or below 100.
    `LPGB_ASSERT_NOW(a_quot_bound, div_valid[QUOT_W] && !div_data[QUOT_W].zero, div_data[QUOT_W].quot <= QUOT_MAX)
    // Red and white scaled channels never exceed their full-brightness levels.
    `LPGB_ASSERT_NOW(a_red_bound, m_valid, m_red_out <= level_reg[CH_RED])
    `LPGB_ASSERT_NOW(a_white_bound, m_valid, m_white_out <= level_reg[CH_WHITE])
    // Input back-pressure only appears with a full pipeline and a stalled result.
    `LPGB_ASSERT_NOW(a_full_when_stalled, !s_ready, m_valid && !m_ready)

endmodule
